/* design/scs_pkg.sv */
// ----------------------------------------------------------------------------
// Command sender package
// Shared types, codes and constants of the sound module command sender.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int VALUE_W      = 16;
    localparam int TICK_W       = 19;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 19;
    localparam int SETTLE_STEPS = 7;

    localparam logic [31:0] CMD_STOP     = 32'h0000_FFFF;
    localparam logic [31:0] CMD_PAUSE    = 32'h0000_FFFE;
    localparam logic [31:0] CMD_VOL_BASE = 32'h0000_FFF0;

    localparam logic [15:0] START_RST  = 16'd1950;
    localparam logic [9:0]  SETUP_RST  = 10'd50;
    localparam logic [9:0]  HOLD_RST   = 10'd50;
    localparam logic [9:0]  HIGH_RST   = 10'd100;
    localparam logic [15:0] STOP_RST   = 16'd1900;
    localparam logic [15:0] RLOW_RST   = 16'd5000;
    localparam logic [18:0] RSET_RST   = 19'd300000;
    localparam logic [15:0] ARM_RST    = 16'd20000;
    localparam logic [2:0]  VOL_LEVEL_TOP = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_SETUP   = 4'd2,
        PH_HOLD    = 4'd3,
        PH_HIGH    = 4'd4,
        PH_STOP    = 4'd5,
        PH_RLOW    = 4'd6,
        PH_RSETTLE = 4'd7,
        PH_ARM     = 4'd8,
        PH_WAIT    = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        FN_TICK      = 3'd0,
        FN_PLAY      = 3'd1,
        FN_PLAY_WAIT = 3'd2,
        FN_STOP      = 3'd3,
        FN_PAUSE     = 3'd4,
        FN_MUTE      = 3'd5,
        FN_UNMUTE    = 3'd6,
        FN_VOLUME    = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BUSY       = 2'd1,
        ST_BAD_VOLUME = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START    = 3'd0,
        CFG_SETUP    = 3'd1,
        CFG_HOLD     = 3'd2,
        CFG_HIGH     = 3'd3,
        CFG_STOP     = 3'd4,
        CFG_RLOW     = 3'd5,
        CFG_RSETTLE  = 3'd6,
        CFG_BUSY_ARM = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic start;
        logic setup;
        logic hold;
        logic high;
        logic stop;
        logic rlow;
        logic rsettle;
        logic arm;
    } t_zero;

    typedef struct packed {
        logic          clock_level;
        logic          data_level;
        logic          reset_level;
        logic          controller_busy;
        logic [1:0]    status;
    } t_result;

    function automatic logic phase_is_zero(input t_phase ph, input t_zero z);
        logic r;
        case (ph)
            PH_START:   r = z.start;
            PH_SETUP:   r = z.setup;
            PH_HOLD:    r = z.hold;
            PH_HIGH:    r = z.high;
            PH_STOP:    r = z.stop;
            PH_RLOW:    r = z.rlow;
            PH_RSETTLE: r = z.rsettle;
            default:    r = z.arm;
        endcase
        return r;
    endfunction

endpackage

/* design/scs_if.sv */
// ----------------------------------------------------------------------------
// Command sender channels
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
interface scs_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [15:0] value;
    logic        do_reset;
    logic        busy_level;

    modport source (output valid, func, value, do_reset, busy_level, input ready);
    modport sink   (input valid, func, value, do_reset, busy_level, output ready);
endinterface

interface scs_out_if;
    logic       valid;
    logic       ready;
    logic       clock_level;
    logic       data_level;
    logic       reset_level;
    logic       controller_busy;
    logic [1:0] status;

    modport source (output valid, clock_level, data_level, reset_level,
                    controller_busy, status, input ready);
    modport sink   (input valid, clock_level, data_level, reset_level,
                    controller_busy, status, output ready);
endinterface

interface scs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [18:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/sound_module_command_sender.sv */
// ----------------------------------------------------------------------------
// Sound module command sender
// Drives the clock, data and reset lines of a voice playback module.
// ----------------------------------------------------------------------------
// Every word on i_in is one timing tick and may carry a command or a reset
// request; every accepted word yields exactly one word on o_out with the line
// levels, the busy flag and the request status for that tick.
// Register writes arrive on i_cfg and are always taken; the user must make
// them only while the block is idle, which the block itself does not enforce.
// A tick is evaluated in the cycle it is accepted: the request check and all
// phase changes whose periods have run out settle in one pass, and the result
// is registered. One tick is accepted per cycle while i_in.ready is high.
// The result register is backed by a one-word skid register. When the
// receiver stalls, one more tick is taken into the skid register and i_in
// then drops ready until the receiver takes a word.
// Synchronous reset returns the lines to clock high, data low, reset high,
// the stored volume to seven, the period registers to their defaults and
// empties both result registers.
// ----------------------------------------------------------------------------
module sound_module_command_sender
    import scs_pkg::*;
#(
    parameter int WORD_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    scs_in_if.sink         i_in,
    scs_cfg_if.sink        i_cfg,
    scs_out_if.source      o_out
);

    localparam int BL_W = $clog2(WORD_BITS + 1);

    typedef struct packed {
        t_phase                phase;
        logic                  fresh;
        logic [BL_W-1:0]       bits;
        logic [WORD_BITS-1:0]  shift;
        logic                  wt;
        logic                  clk;
        logic                  dat;
        logic                  rsl;
    } t_seq;

    function automatic logic [WORD_BITS-1:0] fit_word(input logic [31:0] w);
        return WORD_BITS'(w);
    endfunction

    function automatic t_seq after_bits(input t_seq s, input t_zero z);
        t_seq                 n;
        logic [WORD_BITS-1:0] tail;
        n       = s;
        tail    = s.shift >> (WORD_BITS - int'(s.bits));
        n.fresh = 1'b1;
        if (s.bits != '0) begin
            if (z.setup && z.hold && z.high) begin
                n.dat   = tail[0];
                n.shift = '0;
                n.bits  = '0;
                n.clk   = 1'b1;
                n.phase = PH_STOP;
            end else begin
                n.clk   = 1'b0;
                n.phase = PH_SETUP;
            end
        end else begin
            n.phase = PH_STOP;
        end
        return n;
    endfunction

    function automatic t_seq seq_step(input t_seq s, input logic aged_expired,
                                      input logic busy, input t_zero z);
        t_seq n;
        t_seq h;
        logic expired;
        n       = s;
        h       = s;
        expired = s.fresh ? phase_is_zero(s.phase, z) : aged_expired;
        case (s.phase)
            PH_IDLE: begin
                n = s;
            end
            PH_WAIT: begin
                if (!busy) begin
                    n.phase = PH_IDLE;
                    n.fresh = 1'b1;
                end
            end
            default: begin
                if (expired) begin
                    n.fresh = 1'b1;
                    case (s.phase)
                        PH_START: begin
                            n = after_bits(s, z);
                        end
                        PH_SETUP: begin
                            n.dat   = s.shift[WORD_BITS-1];
                            n.phase = PH_HOLD;
                        end
                        PH_HOLD: begin
                            n.clk   = 1'b1;
                            n.phase = PH_HIGH;
                        end
                        PH_HIGH: begin
                            h.shift = s.shift << 1;
                            if (s.bits != '0) begin
                                h.bits = s.bits - BL_W'(1);
                            end
                            n = after_bits(h, z);
                        end
                        PH_STOP: begin
                            n.phase = s.wt ? PH_ARM : PH_IDLE;
                            n.wt    = 1'b0;
                        end
                        PH_RLOW: begin
                            n.rsl   = 1'b1;
                            n.phase = PH_RSETTLE;
                        end
                        PH_ARM: begin
                            n.phase = PH_WAIT;
                        end
                        default: begin
                            n.phase = PH_IDLE;
                        end
                    endcase
                end
            end
        endcase
        return n;
    endfunction

    logic [15:0]          r_start_ticks;
    logic [9:0]           r_setup_ticks;
    logic [9:0]           r_hold_ticks;
    logic [9:0]           r_high_ticks;
    logic [15:0]          r_stop_ticks;
    logic [15:0]          r_rlow_ticks;
    logic [18:0]          r_rsettle_ticks;
    logic [15:0]          r_arm_ticks;

    t_phase               r_phase;
    logic [TICK_W-1:0]    r_tick;
    logic [WORD_BITS-1:0] r_shift;
    logic [BL_W-1:0]      r_bits;
    logic [2:0]           r_volume;
    logic                 r_wait;
    logic                 r_clock;
    logic                 r_data;
    logic                 r_reset_line;

    t_result              r_out;
    logic                 r_out_valid;
    t_result              r_skid;
    logic                 r_skid_valid;

    t_seq                 n_seq;
    t_seq                 req_seq;
    logic [TICK_W-1:0]    n_tick;
    logic [2:0]           n_volume;
    t_status              req_status;
    t_result              n_result;
    t_zero                zero;
    logic [TICK_W-1:0]    cur_duration;
    logic                 aged_expired;
    logic                 in_accept;
    logic                 out_pop;

    assign in_accept   = i_in.valid && i_in.ready;
    assign out_pop     = r_out_valid && o_out.ready;
    assign i_in.ready  = !r_skid_valid;
    assign i_cfg.ready = 1'b1;

    assign zero.start   = (r_start_ticks == '0);
    assign zero.setup   = (r_setup_ticks == '0);
    assign zero.hold    = (r_hold_ticks == '0);
    assign zero.high    = (r_high_ticks == '0);
    assign zero.stop    = (r_stop_ticks == '0);
    assign zero.rlow    = (r_rlow_ticks == '0);
    assign zero.rsettle = (r_rsettle_ticks == '0);
    assign zero.arm     = (r_arm_ticks == '0);

    always_comb begin
        case (r_phase)
            PH_START:   cur_duration = TICK_W'(r_start_ticks);
            PH_SETUP:   cur_duration = TICK_W'(r_setup_ticks);
            PH_HOLD:    cur_duration = TICK_W'(r_hold_ticks);
            PH_HIGH:    cur_duration = TICK_W'(r_high_ticks);
            PH_STOP:    cur_duration = TICK_W'(r_stop_ticks);
            PH_RLOW:    cur_duration = TICK_W'(r_rlow_ticks);
            PH_RSETTLE: cur_duration = r_rsettle_ticks;
            default:    cur_duration = TICK_W'(r_arm_ticks);
        endcase
    end

    assign aged_expired = (r_tick >= cur_duration);

    always_comb begin
        req_seq.phase = r_phase;
        req_seq.fresh = 1'b0;
        req_seq.bits  = r_bits;
        req_seq.shift = r_shift;
        req_seq.wt    = r_wait;
        req_seq.clk   = r_clock;
        req_seq.dat   = r_data;
        req_seq.rsl   = r_reset_line;
        req_status    = ST_OK;
        n_volume      = r_volume;
        if (i_in.do_reset || (t_func'(i_in.func) != FN_TICK)) begin
            if (r_phase != PH_IDLE) begin
                req_status = ST_BUSY;
            end else if (i_in.do_reset) begin
                req_seq.clk   = 1'b1;
                req_seq.rsl   = 1'b0;
                req_seq.phase = PH_RLOW;
                req_seq.fresh = 1'b1;
            end else begin
                req_seq.bits  = BL_W'(WORD_BITS);
                req_seq.wt    = 1'b0;
                req_seq.clk   = 1'b0;
                req_seq.phase = PH_START;
                req_seq.fresh = 1'b1;
                case (t_func'(i_in.func))
                    FN_PLAY: begin
                        req_seq.shift = fit_word(32'(i_in.value));
                    end
                    FN_PLAY_WAIT: begin
                        req_seq.shift = fit_word(32'(i_in.value));
                        req_seq.wt    = 1'b1;
                    end
                    FN_STOP: begin
                        req_seq.shift = fit_word(CMD_STOP);
                    end
                    FN_PAUSE: begin
                        req_seq.shift = fit_word(CMD_PAUSE);
                    end
                    FN_MUTE: begin
                        req_seq.shift = fit_word(CMD_VOL_BASE);
                    end
                    FN_UNMUTE: begin
                        req_seq.shift = fit_word(CMD_VOL_BASE | 32'(r_volume));
                    end
                    default: begin
                        if (i_in.value <= 16'(VOL_LEVEL_TOP)) begin
                            n_volume      = i_in.value[2:0];
                            req_seq.shift = fit_word(CMD_VOL_BASE | 32'(i_in.value[2:0]));
                        end else begin
                            req_seq.phase = r_phase;
                            req_seq.fresh = 1'b0;
                            req_seq.bits  = r_bits;
                            req_seq.shift = r_shift;
                            req_seq.wt    = r_wait;
                            req_seq.clk   = r_clock;
                            req_status    = ST_BAD_VOLUME;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_seq = req_seq;
        for (int k = 0; k < SETTLE_STEPS; k++) begin
            n_seq = seq_step(n_seq, aged_expired, i_in.busy_level, zero);
        end
    end

    always_comb begin
        if ((n_seq.phase != PH_IDLE) && (n_seq.phase != PH_WAIT)) begin
            n_tick = (n_seq.fresh ? '0 : r_tick) + TICK_W'(1);
        end else begin
            n_tick = r_tick;
        end
    end

    always_comb begin
        n_result.clock_level     = n_seq.clk;
        n_result.data_level      = n_seq.dat;
        n_result.reset_level     = n_seq.rsl;
        n_result.controller_busy = (n_seq.phase != PH_IDLE);
        n_result.status          = req_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_ticks   <= START_RST;
            r_setup_ticks   <= SETUP_RST;
            r_hold_ticks    <= HOLD_RST;
            r_high_ticks    <= HIGH_RST;
            r_stop_ticks    <= STOP_RST;
            r_rlow_ticks    <= RLOW_RST;
            r_rsettle_ticks <= RSET_RST;
            r_arm_ticks     <= ARM_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_START:   r_start_ticks   <= i_cfg.data[15:0];
                CFG_SETUP:   r_setup_ticks   <= i_cfg.data[9:0];
                CFG_HOLD:    r_hold_ticks    <= i_cfg.data[9:0];
                CFG_HIGH:    r_high_ticks    <= i_cfg.data[9:0];
                CFG_STOP:    r_stop_ticks    <= i_cfg.data[15:0];
                CFG_RLOW:    r_rlow_ticks    <= i_cfg.data[15:0];
                CFG_RSETTLE: r_rsettle_ticks <= i_cfg.data;
                default:     r_arm_ticks     <= i_cfg.data[15:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= '0;
            r_shift      <= '0;
            r_bits       <= '0;
            r_volume     <= VOL_LEVEL_TOP;
            r_wait       <= 1'b0;
            r_clock      <= 1'b1;
            r_data       <= 1'b0;
            r_reset_line <= 1'b1;
        end else if (in_accept) begin
            r_phase      <= n_seq.phase;
            r_tick       <= n_tick;
            r_shift      <= n_seq.shift;
            r_bits       <= n_seq.bits;
            r_volume     <= n_volume;
            r_wait       <= n_seq.wt;
            r_clock      <= n_seq.clk;
            r_data       <= n_seq.dat;
            r_reset_line <= n_seq.rsl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_pop) begin
                r_out       <= n_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.clock_level     = r_out.clock_level;
    assign o_out.data_level      = r_out.data_level;
    assign o_out.reset_level     = r_out.reset_level;
    assign o_out.controller_busy = r_out.controller_busy;
    assign o_out.status          = r_out.status;

endmodule

/* design/scs_checker.sv */
// ----------------------------------------------------------------------------
// Command sender checker
// Port-level properties of the command sender, bound to the top level.
// ----------------------------------------------------------------------------
module scs_checker
    import scs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_clock_level,
    input logic       i_data_level,
    input logic       i_reset_level,
    input logic       i_controller_busy,
    input logic [1:0] i_status
);

    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_clock_level)
        && $stable(i_data_level) && $stable(i_reset_level)
        && $stable(i_controller_busy) && $stable(i_status))
        else $error("result word changed while stalled");

    // Ready only drops when a result word is waiting.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending result");

    // A rejected volume leaves the sender idle.
    a_bad_volume_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_BAD_VOLUME) |-> !i_controller_busy)
        else $error("bad volume reported while busy");

    // The reset line is only pulled low during a reset sequence.
    a_reset_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_reset_level |-> i_controller_busy)
        else $error("reset line low while idle");

    // The clock line is only low while a word is being sent.
    a_clock_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_clock_level |-> i_controller_busy)
        else $error("clock line low while idle");

endmodule

bind sound_module_command_sender scs_checker u_scs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_clock_level     (o_out.clock_level),
    .i_data_level      (o_out.data_level),
    .i_reset_level     (o_out.reset_level),
    .i_controller_busy (o_out.controller_busy),
    .i_status          (o_out.status)
);
